/* hw/rtl/ppc_pkg.sv */
// Package for the PRBS pattern checker: pattern selector codes, counter width,
// polynomial tables and the result type of one byte step.
// No dependencies.
package ppc_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int STATE_W     = 31;
  localparam int REPORT_W    = 32;

  localparam logic [2:0] PAT_PRBS7  = 3'd0;
  localparam logic [2:0] PAT_PRBS9  = 3'd1;
  localparam logic [2:0] PAT_PRBS15 = 3'd2;
  localparam logic [2:0] PAT_PRBS23 = 3'd3;
  localparam logic [2:0] PAT_PRBS31 = 3'd4;

  localparam logic       REG_PATTERN_SELECT = 1'b0;
  localparam logic       REG_SEED_VALUE     = 1'b1;

  localparam logic [STATE_W-1:0] ZERO_SEED_FILL = 31'h7E;
  localparam logic [3:0]         BYTE_BITS      = 4'd8;

  typedef struct packed {
    logic [7:0]         expected;
    logic [3:0]         errors;
    logic [3:0]         nvalid;
    logic [STATE_W-1:0] next_state;
  } ppc_step_t;

  // Index of the top state bit, which is the first feedback tap.
  function automatic logic [4:0] poly_msb(input logic [2:0] sel);
    case (sel)
      PAT_PRBS7:  poly_msb = 5'd6;
      PAT_PRBS9:  poly_msb = 5'd8;
      PAT_PRBS23: poly_msb = 5'd22;
      PAT_PRBS31: poly_msb = 5'd30;
      default:    poly_msb = 5'd14;
    endcase
  endfunction

  // Index of the second feedback tap.
  function automatic logic [4:0] poly_tap(input logic [2:0] sel);
    case (sel)
      PAT_PRBS7:  poly_tap = 5'd5;
      PAT_PRBS9:  poly_tap = 5'd4;
      PAT_PRBS23: poly_tap = 5'd17;
      PAT_PRBS31: poly_tap = 5'd27;
      default:    poly_tap = 5'd13;
    endcase
  endfunction

  function automatic logic [STATE_W-1:0] poly_mask(input logic [2:0] sel);
    case (sel)
      PAT_PRBS7:  poly_mask = 31'h7F;
      PAT_PRBS9:  poly_mask = 31'h1FF;
      PAT_PRBS23: poly_mask = 31'h7FFFFF;
      PAT_PRBS31: poly_mask = 31'h7FFFFFFF;
      default:    poly_mask = 31'h7FFF;
    endcase
  endfunction

  function automatic logic [STATE_W-1:0] seed_load(input logic [2:0] sel,
                                                   input logic [STATE_W-1:0] seed);
    logic [STATE_W-1:0] s;
    s = seed & poly_mask(sel);
    seed_load = (s == '0) ? ZERO_SEED_FILL : s;
  endfunction

endpackage

/* hw/rtl/prbs_pattern_checker.sv */
// PRBS pattern checker top level: input register, byte step, saturating totals
// and result register. Depends on ppc_pkg and ppc_lfsr_step.
// Each input transaction is held in the input register until the result register is free.
// Throughput: one byte per cycle unless a result waits in the output register; the
// LFSR state loop closes through the combinational step logic, so back-to-back bytes need no bubbles.
// Reset (synchronous): PRBS7 selected, seed 0x7E loaded, totals cleared.
module prbs_pattern_checker import ppc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,   // [7:0] rx_byte, [11:8] bits_valid, zero fill
  input  logic         s_tuser,   // [0] restart
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [79:0]  m_tdata,   // [7:0] expected_byte, [11:8] byte_errors,
                                  // [43:12] error_total, [75:44] bit_total
  input  logic         cfg_wr_en,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_data
);

  logic [2:0]             pattern_select;
  logic [STATE_W-1:0]     seed_value;
  logic [STATE_W-1:0]     shift_state;
  logic [COUNT_WIDTH-1:0] error_counter;
  logic [COUNT_WIDTH-1:0] bit_counter;

  logic                   in_valid;
  logic [7:0]             in_rx;
  logic [3:0]             in_nvalid;
  logic                   in_restart;

  logic                   out_valid;
  logic [7:0]             out_expected;
  logic [3:0]             out_errors;
  logic [REPORT_W-1:0]    out_err_total;
  logic [REPORT_W-1:0]    out_bit_total;

  logic                   out_free;
  logic                   advance;
  logic [STATE_W-1:0]     step_state;
  logic [COUNT_WIDTH-1:0] err_base;
  logic [COUNT_WIDTH-1:0] bit_base;
  logic [COUNT_WIDTH:0]   err_sum;
  logic [COUNT_WIDTH:0]   bit_sum;
  logic [COUNT_WIDTH-1:0] error_counter_next;
  logic [COUNT_WIDTH-1:0] bit_counter_next;
  logic [REPORT_W-1:0]    err_report;
  logic [REPORT_W-1:0]    bit_report;
  ppc_step_t              step;

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  assign step_state = in_restart ? seed_load(pattern_select, seed_value) : shift_state;
  assign err_base   = in_restart ? '0 : error_counter;
  assign bit_base   = in_restart ? '0 : bit_counter;

  ppc_lfsr_step u_step (
    .state      (step_state),
    .sel        (pattern_select),
    .rx_byte    (in_rx),
    .bits_valid (in_nvalid),
    .result     (step)
  );

  assign err_sum = {1'b0, err_base} + (COUNT_WIDTH + 1)'(step.errors);
  assign bit_sum = {1'b0, bit_base} + (COUNT_WIDTH + 1)'(step.nvalid);
  assign error_counter_next = err_sum[COUNT_WIDTH] ? '1 : err_sum[COUNT_WIDTH-1:0];
  assign bit_counter_next   = bit_sum[COUNT_WIDTH] ? '1 : bit_sum[COUNT_WIDTH-1:0];

  generate
    if (COUNT_WIDTH > REPORT_W) begin : g_rep_clip
      assign err_report = (|error_counter_next[COUNT_WIDTH-1:REPORT_W]) ? '1 :
                          error_counter_next[REPORT_W-1:0];
      assign bit_report = (|bit_counter_next[COUNT_WIDTH-1:REPORT_W]) ? '1 :
                          bit_counter_next[REPORT_W-1:0];
    end else begin : g_rep_ext
      assign err_report = REPORT_W'(error_counter_next);
      assign bit_report = REPORT_W'(bit_counter_next);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_select <= PAT_PRBS7;
      seed_value     <= ZERO_SEED_FILL;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PATTERN_SELECT: pattern_select <= cfg_data[2:0];
        REG_SEED_VALUE:     seed_value     <= cfg_data;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_rx      <= s_tdata[7:0];
      in_nvalid  <= s_tdata[11:8];
      in_restart <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_state   <= ZERO_SEED_FILL;
      error_counter <= '0;
      bit_counter   <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        shift_state   <= step.next_state;
        error_counter <= error_counter_next;
        bit_counter   <= bit_counter_next;
        out_valid     <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_expected  <= step.expected;
      out_errors    <= step.errors;
      out_err_total <= err_report;
      out_bit_total <= bit_report;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_bit_total, out_err_total, out_errors, out_expected};

  // Input side stalls only while a result waits in the output register.
  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without a held result");

  a_byte_errors_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:8] <= 4'd8))
    else $error("byte error count above eight");

  a_errors_within_bits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[43:12] <= m_tdata[75:44]))
    else $error("error total exceeds checked-bit total");

  a_counter_order: assert property (@(posedge clk) disable iff (rst)
    error_counter <= bit_counter)
    else $error("error counter exceeds bit counter");

endmodule

/* hw/rtl/ppc_lfsr_step.sv */
// Up to eight unrolled LFSR steps for one received byte: expected bits, bit errors
// and the state after the byte. Purely combinational.
// Depends on ppc_pkg.
module ppc_lfsr_step import ppc_pkg::*; (
  input  logic [STATE_W-1:0] state,
  input  logic [2:0]         sel,
  input  logic [7:0]         rx_byte,
  input  logic [3:0]         bits_valid,
  output ppc_step_t          result
);

  logic [STATE_W-1:0] mask;
  logic [4:0]         msb;
  logic [4:0]         tap;
  logic [STATE_W-1:0] st;
  logic [3:0]         nv;
  logic [7:0]         expct;
  logic [3:0]         errs;
  logic               pbit;
  logic               fb;

  assign mask = poly_mask(sel);
  assign msb  = poly_msb(sel);
  assign tap  = poly_tap(sel);
  assign nv   = (bits_valid > BYTE_BITS) ? BYTE_BITS : bits_valid;

  always_comb begin
    st    = state & mask;
    expct = '0;
    errs  = '0;
    pbit  = 1'b0;
    fb    = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (4'(b) < nv) begin
        pbit     = st[0];
        expct[b] = pbit;
        errs     = errs + {3'b000, pbit ^ rx_byte[b]};
        fb       = st[msb] ^ st[tap];
        st       = {st[STATE_W-2:0], fb} & mask;
      end
    end
  end

  assign result.expected   = expct;
  assign result.errors     = errs;
  assign result.nvalid     = nv;
  assign result.next_state = st;

endmodule

/* bench/tb_prbs_pattern_checker.sv */
// Self-checking testbench for prbs_pattern_checker: a directed table followed by random
// phases of byte transactions, checked against an in-bench LFSR and totals predictor.
// Depends on ppc_pkg and the prbs_pattern_checker RTL.
module tb_prbs_pattern_checker import ppc_pkg::*;;

  localparam logic [2:0] PAT_UNUSED = 3'd7;
  localparam int         RAND_ITEMS = 1350;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct {
    logic [7:0]          exp_byte;
    logic [3:0]          err_cnt;
    logic [REPORT_W-1:0] err_total;
    logic [REPORT_W-1:0] bit_total;
  } result_t;

  typedef struct {
    logic [7:0]         exp_byte;
    logic [3:0]         err_cnt;
    int                 n;
    logic [STATE_W-1:0] next;
  } step_t;

  typedef struct {
    row_kind_t          kind;
    logic [7:0]         rx;
    logic [3:0]         nv;
    logic               rs;
    logic               idx;
    logic [STATE_W-1:0] val;
    bit                 typed;
    result_t            want;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [15:0]  s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [79:0]  m_tdata;
  logic         cfg_wr_en;
  logic         cfg_index;
  logic [30:0]  cfg_data;

  logic [2:0]          sel_q;
  logic [STATE_W-1:0]  seed_q;
  logic [STATE_W-1:0]  lfsr_q;
  logic [REPORT_W-1:0] err_sum;
  logic [REPORT_W-1:0] bit_sum;

  result_t   pending_results[$];
  stim_row_t plan[$];
  int        fail_count = 0;
  int        mismatch_count = 0;
  int        result_index = 0;
  bit        src_calm = 1'b0;
  bit        sink_calm = 1'b0;

  prbs_pattern_checker u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void poly_of(input logic [2:0] sel, output int len, output int tap);
    case (sel)
      PAT_PRBS7: begin
        len = 7;
        tap = 6;
      end
      PAT_PRBS9: begin
        len = 9;
        tap = 5;
      end
      PAT_PRBS23: begin
        len = 23;
        tap = 18;
      end
      PAT_PRBS31: begin
        len = 31;
        tap = 28;
      end
      default: begin
        len = 15;
        tap = 14;
      end
    endcase
  endfunction

  function automatic logic [STATE_W-1:0] seed_fill(input logic [2:0] sel,
                                                   input logic [STATE_W-1:0] seed);
    int len;
    int tap;
    logic [STATE_W-1:0] s;
    poly_of(sel, len, tap);
    s = seed & ({STATE_W{1'b1}} >> (STATE_W - len));
    return (s == '0) ? STATE_W'(8'h7E) : s;
  endfunction

  function automatic step_t pattern_step(input logic [2:0] sel, input logic [STATE_W-1:0] st0,
                                         input logic [3:0] nv, input logic [7:0] rx);
    step_t r;
    int len;
    int tap;
    logic [STATE_W-1:0] m;
    logic [STATE_W-1:0] st;
    logic pb;
    logic fb;
    poly_of(sel, len, tap);
    m = {STATE_W{1'b1}} >> (STATE_W - len);
    r.n = (nv > 4'd8) ? 8 : int'(nv);
    r.exp_byte = '0;
    r.err_cnt = '0;
    st = st0 & m;
    for (int b = 0; b < r.n; b++) begin
      pb = st[0];
      fb = st[len-1] ^ st[tap-1];
      r.exp_byte[b] = pb;
      if (pb != rx[b]) r.err_cnt = r.err_cnt + 4'd1;
      st = ((st << 1) | STATE_W'(fb)) & m;
    end
    r.next = st;
    return r;
  endfunction

  function automatic logic [REPORT_W-1:0] sat_add(input logic [REPORT_W-1:0] a,
                                                  input logic [REPORT_W-1:0] b);
    logic [REPORT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[REPORT_W] ? {REPORT_W{1'b1}} : s[REPORT_W-1:0];
  endfunction

  task automatic predict_byte(input logic [7:0] rx, input logic [3:0] nv, input logic rs,
                              output result_t r);
    step_t s;
    if (rs) begin
      lfsr_q = seed_fill(sel_q, seed_q);
      err_sum = '0;
      bit_sum = '0;
    end
    s = pattern_step(sel_q, lfsr_q, nv, rx);
    lfsr_q = s.next;
    err_sum = sat_add(err_sum, REPORT_W'(s.err_cnt));
    bit_sum = sat_add(bit_sum, REPORT_W'(s.n));
    r.exp_byte = s.exp_byte;
    r.err_cnt = s.err_cnt;
    r.err_total = err_sum;
    r.bit_total = bit_sum;
  endtask

  function automatic stim_row_t byte_row(input logic [7:0] rx, input logic [3:0] nv,
                                         input logic rs);
    stim_row_t r;
    r.kind = ROW_BYTE;
    r.rx = rx;
    r.nv = nv;
    r.rs = rs;
    r.idx = REG_PATTERN_SELECT;
    r.val = '0;
    r.typed = 1'b0;
    r.want.exp_byte = '0;
    r.want.err_cnt = '0;
    r.want.err_total = '0;
    r.want.bit_total = '0;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] rx, input logic [3:0] nv,
                                          input logic rs, input logic [7:0] eb,
                                          input logic [3:0] ec, input int et, input int bt);
    stim_row_t r;
    r = byte_row(rx, nv, rs);
    r.typed = 1'b1;
    r.want.exp_byte = eb;
    r.want.err_cnt = ec;
    r.want.err_total = REPORT_W'(et);
    r.want.bit_total = REPORT_W'(bt);
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic idx, input logic [STATE_W-1:0] val);
    stim_row_t r;
    r = byte_row(8'h00, 4'd0, 1'b0);
    r.kind = ROW_CFG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  task automatic write_reg(input logic idx, input logic [STATE_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_PATTERN_SELECT) sel_q = val[2:0];
    else seed_q = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_byte(input logic [7:0] rx, input logic [3:0] nv, input logic rs,
                           input bit typed, input result_t want);
    int gap;
    result_t predicted;
    gap = src_calm ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'h0, nv, rx};
    s_tuser <= rs;
    do @(posedge clk); while (s_tready !== 1'b1);
    predict_byte(rx, nv, rs, predicted);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Stops the source and waits for every outstanding transaction to come back.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    int stall;
    result_t got;
    result_t want;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = sink_calm ? 0 : $urandom_range(0, 4);
      @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      got.exp_byte = m_tdata[7:0];
      got.err_cnt = m_tdata[11:8];
      got.err_total = m_tdata[43:12];
      got.bit_total = m_tdata[75:44];
      if (pending_results.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("result %0d arrived with nothing outstanding: byte %h errors %0d",
                   result_index, got.exp_byte, got.err_cnt);
      end else begin
        want = pending_results.pop_front();
        if (got.exp_byte !== want.exp_byte || got.err_cnt !== want.err_cnt ||
            got.err_total !== want.err_total || got.bit_total !== want.bit_total) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d mismatch: expected %h/%0d/%0d/%0d, got %h/%0d/%0d/%0d",
                     result_index, want.exp_byte, want.err_cnt, want.err_total,
                     want.bit_total, got.exp_byte, got.err_cnt, got.err_total,
                     got.bit_total);
        end
      end
      result_index++;
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int sent;
    int plen;
    logic rs;
    logic [3:0] nv;
    logic [7:0] rx;
    logic [7:0] vmask;
    logic [7:0] flip;
    logic [STATE_W-1:0] start;
    logic [STATE_W-1:0] seed;
    step_t peek;
    result_t blank;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_PATTERN_SELECT;
    cfg_data = '0;
    sel_q = PAT_PRBS7;
    seed_q = STATE_W'(8'h7E);
    lfsr_q = seed_fill(sel_q, seed_q);
    err_sum = '0;
    bit_sum = '0;
    blank = '{default: '0};

    plan.push_back(typed_row(8'h40, 4'd8,  1'b0, 8'h40, 4'd0, 0, 8));
    plan.push_back(typed_row(8'hBF, 4'd8,  1'b1, 8'h40, 4'd8, 8, 8));
    plan.push_back(typed_row(8'h00, 4'd0,  1'b0, 8'h00, 4'd0, 8, 8));
    plan.push_back(byte_row (8'hFF, 4'd15, 1'b0));
    plan.push_back(byte_row (8'h5A, 4'd1,  1'b0));
    plan.push_back(byte_row (8'hA5, 4'd7,  1'b0));
    plan.push_back(byte_row (8'h3C, 4'd9,  1'b0));
    plan.push_back(cfg_row  (REG_PATTERN_SELECT, STATE_W'(PAT_PRBS9)));
    plan.push_back(byte_row (8'hFF, 4'd8,  1'b1));
    plan.push_back(byte_row (8'h00, 4'd8,  1'b0));
    plan.push_back(cfg_row  (REG_SEED_VALUE, 31'h7FFFFFFF));
    plan.push_back(cfg_row  (REG_PATTERN_SELECT, STATE_W'(PAT_PRBS31)));
    plan.push_back(byte_row (8'h12, 4'd8,  1'b1));
    plan.push_back(byte_row (8'hED, 4'd8,  1'b0));
    plan.push_back(cfg_row  (REG_PATTERN_SELECT, STATE_W'(PAT_PRBS23)));
    plan.push_back(byte_row (8'h00, 4'd8,  1'b1));
    plan.push_back(cfg_row  (REG_PATTERN_SELECT, STATE_W'(PAT_PRBS15)));
    plan.push_back(byte_row (8'hFF, 4'd8,  1'b1));
    plan.push_back(cfg_row  (REG_PATTERN_SELECT, STATE_W'(PAT_UNUSED)));
    plan.push_back(cfg_row  (REG_SEED_VALUE, 31'h7FFF8000));
    plan.push_back(typed_row(8'h7E, 4'd8,  1'b1, 8'h00, 4'd6, 6, 8));
    plan.push_back(cfg_row  (REG_PATTERN_SELECT, STATE_W'(PAT_PRBS7)));
    plan.push_back(cfg_row  (REG_SEED_VALUE, 31'h0));
    plan.push_back(typed_row(8'h40, 4'd8,  1'b1, 8'h40, 4'd0, 0, 8));
    plan.push_back(cfg_row  (REG_SEED_VALUE, 31'h80));
    plan.push_back(cfg_row  (REG_PATTERN_SELECT, STATE_W'(PAT_PRBS9)));
    plan.push_back(typed_row(8'h55, 4'd0,  1'b1, 8'h00, 4'd0, 0, 0));
    // Narrowing to PRBS7 leaves a zero register, which must then stay at zero.
    plan.push_back(cfg_row  (REG_PATTERN_SELECT, STATE_W'(PAT_PRBS7)));
    plan.push_back(typed_row(8'hFF, 4'd8,  1'b0, 8'h00, 4'd8, 8, 8));
    plan.push_back(typed_row(8'h00, 4'd8,  1'b0, 8'h00, 4'd0, 8, 16));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_byte(plan[i].rx, plan[i].nv, plan[i].rs, plan[i].typed, plan[i].want);
      end
    end

    sent = 0;
    while (sent < RAND_ITEMS) begin
      settle();
      if ($urandom_range(0, 3) != 0)
        write_reg(REG_PATTERN_SELECT, ($urandom_range(0, 9) < 8) ?
                  STATE_W'($urandom_range(0, 4)) : STATE_W'($urandom_range(5, 7)));
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 4))
          0: seed = '0;
          1: seed = {STATE_W{1'b1}};
          2: seed = STATE_W'($urandom_range(0, 255));
          default: seed = STATE_W'($urandom);
        endcase
        write_reg(REG_SEED_VALUE, seed);
      end
      src_calm = ($urandom_range(0, 4) == 0);
      sink_calm = ($urandom_range(0, 4) == 0);
      plen = $urandom_range(10, 80);
      for (int i = 0; i < plen; i++) begin
        rs = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 39) == 0);
        nv = ($urandom_range(0, 4) != 0) ? 4'd8 : 4'($urandom_range(0, 15));
        start = rs ? seed_fill(sel_q, seed_q) : lfsr_q;
        peek = pattern_step(sel_q, start, nv, 8'h00);
        vmask = 8'hFF >> (8 - peek.n);
        case ($urandom_range(0, 9))
          7, 8: flip = 8'h01 << $urandom_range(0, 7);
          9: flip = 8'($urandom);
          default: flip = 8'h00;
        endcase
        rx = ((peek.exp_byte ^ flip) & vmask) | (8'($urandom) & ~vmask);
        send_byte(rx, nv, rs, 1'b0, blank);
        sent++;
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
